[hdl/pmst_pkg.sv]
// Shared types and constants for the Prim minimum spanning tree block.
// Used by pmst_edge_scan and prim_minimum_spanning_tree; depends on nothing.
package pmst_pkg;

    localparam int VTX_W        = 4;
    localparam int MAX_VERTICES = 1 << VTX_W;
    localparam int WEIGHT_W     = 16;
    localparam int CFG_COUNT_W  = 5;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 5;

    typedef logic [VTX_W-1:0] vertex_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_VERTEX = 2'd1;

    typedef struct packed {
        vertex_t             edge_from;
        vertex_t             edge_to;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                last_edge;
    } edge_in_t;

    typedef struct packed {
        vertex_t             tree_vertex;
        logic [WEIGHT_W-1:0] join_weight;
        logic                last_result;
    } tree_out_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

endpackage

[hdl/prim_minimum_spanning_tree.sv]
// Top level of the Prim minimum spanning tree block: loader, tree marks,
// run sequencer and result register. Depends on pmst_pkg and pmst_edge_scan.
//
//  channel   direction  handshake            beat
//  edge      in         edge_valid/stall     one edge_in_t (endpoints, weight, last)
//  tree      out        tree_valid/stall     one tree_out_t (vertex, weight, last)
//  cfg       in         cfg_valid/ready      register index and write data
//
// Edges load one per cycle. An edge beat with last_edge set starts a run and
// stalls the edge channel until the run ends. Each round of the run scans
// every stored edge through the single read port of the edge memory, then
// emits one vertex from the result register in its result cycle. Reset clears
// control state and tree marks at once; the edge memory needs no clearing
// pass. A stalled result register holds the run in its result cycle.
module prim_minimum_spanning_tree #(
    parameter int MAX_EDGES    = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 edge_valid,
    output logic                                 edge_stall,
    input  pmst_pkg::edge_in_t                   edge_data,
    output logic                                 tree_valid,
    input  logic                                 tree_stall,
    output pmst_pkg::tree_out_t                  tree_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmst_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pmst_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pmst_pkg::*;

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = ($clog2(MAX_VERTICES + 1) > CFG_COUNT_W) ?
                        $clog2(MAX_VERTICES + 1) : CFG_COUNT_W;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CFG_COUNT_W-1:0]  vcount_reg;
    vertex_t                 start_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic [MAX_VERTICES-1:0] in_tree_reg, in_tree_next;
    vertex_t                 pend_v_reg, pend_v_next;
    logic [WEIGHT_W-1:0]     pend_w_reg, pend_w_next;
    logic                    out_valid_reg, out_valid_next;
    tree_out_t               out_data_reg, out_data_next;

    logic [NW-1:0]           vc_ext, n_eff;
    logic                    accept, store_ok, emit_go, scan_start;
    vertex_t                 root;
    scan_status_t            scan_st;
    vertex_t                 best_v;
    logic [WEIGHT_W-1:0]     best_w;

    // effective vertex count: zero acts as one, clamp to capacity
    assign vc_ext = NW'(vcount_reg);
    assign n_eff  = (vc_ext == '0) ? NW'(1) :
                    (vc_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_ext;

    assign edge_stall = (state_reg != ST_LOAD);
    assign accept     = edge_valid && !edge_stall;

    // drop edges with an endpoint out of range or with the store full
    assign store_ok = accept &&
                      (NW'(edge_data.edge_from) < n_eff) &&
                      (NW'(edge_data.edge_to) < n_eff) &&
                      (count_reg < CW'(MAX_EDGES));

    // start out of range falls back to vertex zero
    assign root = (NW'(start_reg) < n_eff) ? start_reg : '0;

    // result slot is free when empty or draining this cycle
    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || !tree_stall);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        in_tree_next   = in_tree_reg;
        pend_v_next    = pend_v_reg;
        pend_w_next    = pend_w_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && tree_stall;
        scan_start     = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (store_ok)
                begin
                    count_next = count_reg + CW'(1);
                end
                if (accept && edge_data.last_edge)
                begin
                    in_tree_next            = '0;
                    in_tree_next[VW'(root)] = 1'b1;
                    pend_v_next             = root;
                    pend_w_next             = '0;
                    scan_start              = 1'b1;
                    state_next              = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_st.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    // the held vertex goes out; it is last when no edge crosses the cut
                    out_valid_next            = 1'b1;
                    out_data_next.tree_vertex = pend_v_reg;
                    out_data_next.join_weight = pend_w_reg;
                    out_data_next.last_result = !scan_st.found;
                    if (scan_st.found)
                    begin
                        in_tree_next[VW'(best_v)] = 1'b1;
                        pend_v_next               = best_v;
                        pend_w_next               = best_w;
                        scan_start                = 1'b1;
                        state_next                = ST_SCAN;
                    end
                    else
                    begin
                        in_tree_next = '0;
                        count_next   = '0;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            vcount_reg    <= CFG_COUNT_W'(16);
            start_reg     <= '0;
            count_reg     <= '0;
            in_tree_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            in_tree_reg   <= in_tree_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VERTEX_COUNT: vcount_reg <= cfg_data[CFG_COUNT_W-1:0];
                    CFG_START_VERTEX: start_reg  <= cfg_data[VTX_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_v_reg   <= pend_v_next;
        pend_w_reg   <= pend_w_next;
        out_data_reg <= out_data_next;
    end

    pmst_edge_scan #(
        .MAX_EDGES    (MAX_EDGES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (store_ok),
        .wr_addr     (count_reg[AW-1:0]),
        .wr_from     (edge_data.edge_from),
        .wr_to       (edge_data.edge_to),
        .wr_weight   (edge_data.edge_weight),
        .start       (scan_start),
        .edge_count  (count_reg),
        .in_tree     (in_tree_reg),
        .status      (scan_st),
        .best_vertex (best_v),
        .best_weight (best_w)
    );

    assign cfg_ready  = 1'b1;
    assign tree_valid = out_valid_reg;
    assign tree_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // a new result appears only from the result cycle of a run
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tree_valid) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared outside the result cycle");

    // the scanner finishes only while the sequencer waits for it
    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_st.done |-> (state_reg == ST_SCAN))
        else $error("scan finished outside a scan round");

    // the final result of a run leaves an empty store and no tree marks
    a_run_cleanup: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && !scan_st.found) |=>
            ((state_reg == ST_LOAD) && (count_reg == '0) && (in_tree_reg == '0)))
        else $error("run did not clean up after its final result");

    // a run always holds at least the root in the tree
    a_tree_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (in_tree_reg != '0))
        else $error("run in progress with no tree vertex");
`endif

endmodule

[hdl/pmst_edge_scan.sv]
// Edge store and scan datapath: one synchronous memory, at most one read per cycle.
// Depends on pmst_pkg.
module pmst_edge_scan #(
    parameter int MAX_EDGES    = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] wr_addr,
    input  pmst_pkg::vertex_t                  wr_from,
    input  pmst_pkg::vertex_t                  wr_to,
    input  logic [pmst_pkg::WEIGHT_W-1:0]      wr_weight,
    input  logic                               start,
    input  logic [$clog2(MAX_EDGES+1)-1:0]     edge_count,
    input  logic [pmst_pkg::MAX_VERTICES-1:0]  in_tree,
    output pmst_pkg::scan_status_t             status,
    output pmst_pkg::vertex_t                  best_vertex,
    output logic [pmst_pkg::WEIGHT_W-1:0]      best_weight
);
    import pmst_pkg::*;

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = 2 * VTX_W + WEIGHT_W;

    logic [EW-1:0] mem [MAX_EDGES];
    logic [EW-1:0] rd_data_reg;

    logic          active_reg, active_next;
    logic [CW-1:0] iss_cnt_reg, iss_cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          found_reg, found_next;
    vertex_t       best_v_reg, best_v_next;
    logic [WEIGHT_W-1:0] best_w_reg, best_w_next;

    logic                   issue;
    vertex_t                e_from, e_to, outside;
    logic [WEIGHT_W-1:0]    e_w;
    logic                   in_a, in_b, better;

    assign issue = active_reg && (iss_cnt_reg < edge_count);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_from, wr_to, wr_weight};
        end
        if (issue)
        begin
            rd_data_reg <= mem[iss_cnt_reg[AW-1:0]];
        end
    end

    assign e_from  = rd_data_reg[EW-1 -: VTX_W];
    assign e_to    = rd_data_reg[EW-VTX_W-1 -: VTX_W];
    assign e_w     = rd_data_reg[WEIGHT_W-1:0];
    assign in_a    = in_tree[VW'(e_from)];
    assign in_b    = in_tree[VW'(e_to)];
    assign outside = in_a ? e_to : e_from;

    // candidate wins on lower weight, then on lower vertex index
    assign better = rd_pend_reg && (in_a != in_b) &&
                    (!found_reg || (e_w < best_w_reg) ||
                     ((e_w == best_w_reg) && (outside < best_v_reg)));

    always_comb
    begin
        active_next  = active_reg;
        iss_cnt_next = iss_cnt_reg;
        rd_pend_next = issue;
        found_next   = found_reg;
        best_v_next  = best_v_reg;
        best_w_next  = best_w_reg;
        if (start)
        begin
            active_next  = 1'b1;
            iss_cnt_next = '0;
            rd_pend_next = 1'b0;
            found_next   = 1'b0;
        end
        else
        begin
            if (issue)
            begin
                iss_cnt_next = iss_cnt_reg + CW'(1);
            end
            if (better)
            begin
                found_next  = 1'b1;
                best_v_next = outside;
                best_w_next = e_w;
            end
            if (active_reg && !issue && !rd_pend_reg)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            iss_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            iss_cnt_reg <= iss_cnt_next;
            rd_pend_reg <= rd_pend_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_v_reg <= best_v_next;
        best_w_reg <= best_w_next;
    end

    assign status.done  = active_reg && !issue && !rd_pend_reg;
    assign status.found = found_reg;
    assign best_vertex  = best_v_reg;
    assign best_weight  = best_w_reg;

endmodule
